### hw/rtl/acbr_pkg.sv
package acbr_pkg;

    // layer geometry
    localparam int KERNEL = 3;
    localparam int STRIDE = 1;
    localparam int CH_IN  = 8;
    localparam int CH_OUT = 8;
    localparam int W_IN   = 16;
    localparam int H_IN   = 16;

    // store sizes
    localparam int FEAT_DEPTH = H_IN * W_IN * CH_IN;
    localparam int WGT_DEPTH  = KERNEL * KERNEL * CH_IN * CH_OUT;
    localparam int NTAP       = KERNEL * KERNEL * CH_IN;

    localparam int FEAT_AW = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
    localparam int WGT_AW  = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
    localparam int CHO_AW  = (CH_OUT > 1) ? $clog2(CH_OUT) : 1;
    localparam int K_W     = (KERNEL > 1) ? $clog2(KERNEL) : 1;
    localparam int CI_W    = (CH_IN > 1) ? $clog2(CH_IN) : 1;
    localparam int TAP_W   = (NTAP > 1) ? $clog2(NTAP) : 1;

    // field widths
    localparam int CMD_W  = 3;
    localparam int ADDR_W = 11;
    localparam int DATA_W = 16;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 4;
    localparam int CHAN_W = 3;
    localparam int VAL_W  = 15;

    // arithmetic
    localparam int AD_W    = 16;
    localparam int ACC_W   = 32;
    localparam int PROD_W  = 48;
    localparam int FRAC    = 8;
    localparam int VAL_MAX = 32767;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_FEAT  = 3'd0,
        CMD_LOAD_WGT   = 3'd1,
        CMD_LOAD_SCALE = 3'd2,
        CMD_LOAD_SHIFT = 3'd3,
        CMD_COMPUTE    = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [ADDR_W-1:0]        addr;
        logic signed [DATA_W-1:0] data;
        logic [ROW_W-1:0]         out_row;
        logic [COL_W-1:0]         out_col;
        logic [CHAN_W-1:0]        out_chan;
    } req_t;

    typedef struct packed {
        logic [VAL_W-1:0]  result_value;
        logic [ROW_W-1:0]  res_row;
        logic [COL_W-1:0]  res_col;
        logic [CHAN_W-1:0] res_chan;
        logic              saturated;
    } res_t;

    // per-tap control travelling alongside the store reads
    typedef struct packed {
        logic valid;
        logic in_map;
        logic last;
    } tap_ctl_t;

endpackage

### hw/rtl/acbr_ram.sv
module acbr_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/acbr_seq.sv
module acbr_seq import acbr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [ROW_W-1:0]   row,
    input  logic [COL_W-1:0]   col,
    input  logic [CHAN_W-1:0]  chan,
    output logic [FEAT_AW-1:0] feat_addr,
    output logic [WGT_AW-1:0]  wgt_addr,
    output tap_ctl_t           tap
);

    logic             run_reg;
    logic [K_W-1:0]   ky_reg;
    logic [K_W-1:0]   kx_reg;
    logic [CI_W-1:0]  ci_reg;
    logic [TAP_W-1:0] tap_reg;

    logic [31:0] h_full;
    logic [31:0] w_full;
    logic [31:0] fi_full;
    logic [31:0] wi_full;
    logic        last_tap;

    // window position and store addresses of the current tap
    always_comb
    begin
        h_full    = 32'(row) * STRIDE + 32'(ky_reg);
        w_full    = 32'(col) * STRIDE + 32'(kx_reg);
        fi_full   = (h_full * W_IN + w_full) * CH_IN + 32'(ci_reg);
        wi_full   = 32'(tap_reg) * CH_OUT + 32'(chan);
        feat_addr = fi_full[FEAT_AW-1:0];
        wgt_addr  = wi_full[WGT_AW-1:0];
        last_tap  = (ky_reg == K_W'(KERNEL - 1)) && (kx_reg == K_W'(KERNEL - 1))
                    && (ci_reg == CI_W'(CH_IN - 1));
        tap.valid  = run_reg;
        tap.in_map = (h_full < H_IN) && (w_full < W_IN);
        tap.last   = run_reg && last_tap;
    end

    // walk channels innermost, then kernel column, then kernel row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            ky_reg  <= '0;
            kx_reg  <= '0;
            ci_reg  <= '0;
            tap_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            ky_reg  <= '0;
            kx_reg  <= '0;
            ci_reg  <= '0;
            tap_reg <= '0;
        end
        else if (run_reg)
        begin
            tap_reg <= tap_reg + 1'b1;
            if (last_tap)
            begin
                run_reg <= 1'b0;
            end
            if (ci_reg == CI_W'(CH_IN - 1))
            begin
                ci_reg <= '0;
                if (kx_reg == K_W'(KERNEL - 1))
                begin
                    kx_reg <= '0;
                    ky_reg <= ky_reg + 1'b1;
                end
                else
                begin
                    kx_reg <= kx_reg + 1'b1;
                end
            end
            else
            begin
                ci_reg <= ci_reg + 1'b1;
            end
        end
    end

endmodule

### hw/rtl/acbr_dp.sv
module acbr_dp import acbr_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  tap_ctl_t                 tap,
    input  logic signed [DATA_W-1:0] feat,
    input  logic signed [DATA_W-1:0] wgt,
    input  logic signed [DATA_W-1:0] scale,
    input  logic signed [DATA_W-1:0] shift,
    output logic                     done,
    output logic [VAL_W-1:0]         value,
    output logic                     saturated
);

    tap_ctl_t                 tap1_reg;
    logic [AD_W-1:0]          ad_reg;
    logic                     ad_valid_reg;
    logic                     last2_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     last3_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     mul_reg;
    logic                     done_reg;
    logic [VAL_W-1:0]         value_reg;
    logic                     sat_reg;

    logic signed [DATA_W:0]   diff;
    logic [DATA_W:0]          diff_abs;
    logic signed [PROD_W-1:0] scale_x;
    logic signed [PROD_W-1:0] acc_x;
    logic signed [PROD_W-1:0] sum_v;

    // absolute difference of the registered store reads
    always_comb
    begin
        diff     = {feat[DATA_W-1], feat} - {wgt[DATA_W-1], wgt};
        diff_abs = diff[DATA_W] ? 17'(-diff) : 17'(diff);
    end

    // scale, floor shift by the fraction bits, add shift
    always_comb
    begin
        scale_x = PROD_W'(scale);
        acc_x   = PROD_W'(acc_reg);
        sum_v   = (prod_reg >>> FRAC) + PROD_W'(shift);
    end

    // tap pipeline, accumulator, then multiply and clip steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap1_reg     <= '0;
            ad_reg       <= '0;
            ad_valid_reg <= 1'b0;
            last2_reg    <= 1'b0;
            acc_reg      <= '0;
            last3_reg    <= 1'b0;
            prod_reg     <= '0;
            mul_reg      <= 1'b0;
            done_reg     <= 1'b0;
            value_reg    <= '0;
            sat_reg      <= 1'b0;
        end
        else
        begin
            tap1_reg     <= tap;
            ad_reg       <= diff_abs[AD_W-1:0];
            ad_valid_reg <= tap1_reg.valid && tap1_reg.in_map;
            last2_reg    <= tap1_reg.last;
            last3_reg    <= last2_reg;
            mul_reg      <= last3_reg;
            done_reg     <= mul_reg;

            if (start)
            begin
                acc_reg <= '0;
            end
            else if (ad_valid_reg)
            begin
                acc_reg <= acc_reg - $signed({{(ACC_W - AD_W){1'b0}}, ad_reg});
            end

            if (last3_reg)
            begin
                prod_reg <= scale_x * acc_x;
            end

            if (mul_reg)
            begin
                if (sum_v < 0)
                begin
                    value_reg <= '0;
                    sat_reg   <= 1'b0;
                end
                else if (sum_v > PROD_W'(VAL_MAX))
                begin
                    value_reg <= VAL_W'(VAL_MAX);
                    sat_reg   <= 1'b1;
                end
                else
                begin
                    value_reg <= sum_v[VAL_W-1:0];
                    sat_reg   <= 1'b0;
                end
            end
        end
    end

    assign done      = done_reg;
    assign value     = value_reg;
    assign saturated = sat_reg;

endmodule

### hw/rtl/adder_conv_bn_relu.sv
// channel   dir  handshake             payload
// req       in   req_valid/req_stall   req_t: command, addr, data, out_row/col/chan
// rsp       out  rsp_valid/rsp_stall   res_t: result_value, res_row/col/chan, saturated
//
// a load request gives no response
// a compute request takes one feature/weight read pair per cycle into the accumulator,
// then multiply and clip; the response register loads once its slot is free
// an output channel not below CH_OUT answers zero without a compute pass
// req_stall is high while a compute request is in flight; a result waiting for the response register holds it
// stores are not cleared by reset; rst_n clears only the control state
module adder_conv_bn_relu import acbr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output res_t rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_HOLD
    } state_t;

    state_t              state_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic                zero_reg;
    logic                rsp_valid_reg;
    res_t                rsp_reg;

    logic signed [DATA_W-1:0] scale_mem [CH_OUT];
    logic signed [DATA_W-1:0] shift_mem [CH_OUT];
    logic signed [DATA_W-1:0] scale_q_reg;
    logic signed [DATA_W-1:0] shift_q_reg;

    logic                accept;
    logic                is_compute;
    logic                chan_ok;
    logic                start;
    logic [31:0]         addr_ext;
    logic [31:0]         chan_ext;
    logic                feat_we;
    logic                wgt_we;
    logic                scale_we;
    logic                shift_we;
    logic [FEAT_AW-1:0]  feat_raddr;
    logic [WGT_AW-1:0]   wgt_raddr;
    logic [DATA_W-1:0]   feat_q;
    logic [DATA_W-1:0]   wgt_q;
    tap_ctl_t            tap;
    logic                dp_done;
    logic [VAL_W-1:0]    dp_value;
    logic                dp_sat;
    logic                rsp_free;
    logic                rsp_load;

    // request decode
    always_comb
    begin
        accept     = req_valid && !req_stall;
        is_compute = (req.command == CMD_COMPUTE);
        addr_ext   = 32'(req.addr);
        chan_ext   = 32'(chan_reg);
        chan_ok    = 32'(req.out_chan) < CH_OUT;
        start      = accept && is_compute && chan_ok;
        feat_we    = accept && (req.command == CMD_LOAD_FEAT) && (addr_ext < FEAT_DEPTH);
        wgt_we     = accept && (req.command == CMD_LOAD_WGT) && (addr_ext < WGT_DEPTH);
        scale_we   = accept && (req.command == CMD_LOAD_SCALE) && (addr_ext < CH_OUT);
        shift_we   = accept && (req.command == CMD_LOAD_SHIFT) && (addr_ext < CH_OUT);
        rsp_free   = !rsp_valid_reg || !rsp_stall;
        rsp_load   = (state_reg == ST_HOLD) && rsp_free;
    end

    assign req_stall = (state_reg != ST_IDLE);

    // feature and weight stores
    acbr_ram #(
        .DEPTH (FEAT_DEPTH),
        .WIDTH (DATA_W)
    ) u_feat (
        .clk   (clk),
        .we    (feat_we),
        .waddr (addr_ext[FEAT_AW-1:0]),
        .wdata (req.data),
        .raddr (feat_raddr),
        .rdata (feat_q)
    );

    acbr_ram #(
        .DEPTH (WGT_DEPTH),
        .WIDTH (DATA_W)
    ) u_wgt (
        .clk   (clk),
        .we    (wgt_we),
        .waddr (addr_ext[WGT_AW-1:0]),
        .wdata (req.data),
        .raddr (wgt_raddr),
        .rdata (wgt_q)
    );

    // per-channel scale and shift, read at the held channel
    always_ff @(posedge clk)
    begin
        if (scale_we)
        begin
            scale_mem[addr_ext[CHO_AW-1:0]] <= req.data;
        end
        if (shift_we)
        begin
            shift_mem[addr_ext[CHO_AW-1:0]] <= req.data;
        end
        scale_q_reg <= scale_mem[chan_ext[CHO_AW-1:0]];
        shift_q_reg <= shift_mem[chan_ext[CHO_AW-1:0]];
    end

    // tap address walk
    acbr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .row       (row_reg),
        .col       (col_reg),
        .chan      (chan_reg),
        .feat_addr (feat_raddr),
        .wgt_addr  (wgt_raddr),
        .tap       (tap)
    );

    // shared accumulate and scale unit
    acbr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .tap       (tap),
        .feat      ($signed(feat_q)),
        .wgt       ($signed(wgt_q)),
        .scale     (scale_q_reg),
        .shift     (shift_q_reg),
        .done      (dp_done),
        .value     (dp_value),
        .saturated (dp_sat)
    );

    // control state and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            chan_reg      <= '0;
            zero_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && is_compute)
                    begin
                        row_reg   <= req.out_row;
                        col_reg   <= req.out_col;
                        chan_reg  <= req.out_chan;
                        zero_reg  <= !chan_ok;
                        state_reg <= chan_ok ? ST_BUSY : ST_HOLD;
                    end
                end
                ST_BUSY:
                begin
                    if (dp_done)
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg.result_value <= zero_reg ? '0 : dp_value;
                        rsp_reg.saturated    <= zero_reg ? 1'b0 : dp_sat;
                        rsp_reg.res_row      <= row_reg;
                        rsp_reg.res_col      <= col_reg;
                        rsp_reg.res_chan     <= chan_reg;
                        state_reg            <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### test/testbench.sv
module testbench;
    import acbr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run length and timing bounds
    localparam int RANDOM_ITEMS = 850;
    localparam int MAX_WAIT     = 19;
    localparam int DRAIN_CYCLES = NTAP + 5 + 40;
    localparam int CYCLE_LIMIT  = 3_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    res_t rsp;

    adder_conv_bn_relu u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // shadow copies of the layer stores
    logic signed [DATA_W-1:0] feat_mem [FEAT_DEPTH];
    logic signed [DATA_W-1:0] wgt_mem [WGT_DEPTH];
    logic signed [DATA_W-1:0] scale_mem [CH_OUT];
    logic signed [DATA_W-1:0] shift_mem [CH_OUT];

    req_t pending_reqs [$];
    res_t expected_results [$];

    int  n_errors = 0;
    int  n_accepted = 0;
    int  n_results = 0;
    int  n_saturated = 0;
    int  cycle_count = 0;
    int  req_gap = 0;
    int  rsp_wait = 0;
    bit  req_quiet = 1'b0;
    bit  rsp_quiet = 1'b0;

    function automatic int feat_addr(int h, int w, int c);
        return (h * W_IN + w) * CH_IN + c;
    endfunction

    function automatic int wgt_addr(int ky, int kx, int c, int o);
        return ((ky * KERNEL + kx) * CH_IN + c) * CH_OUT + o;
    endfunction

    // expected output of one compute request against the shadow stores
    function automatic res_t conv_result(req_t r);
        res_t   o;
        int     row;
        int     col;
        int     chan;
        int     h;
        int     w;
        int     a;
        int     b;
        int     acc;
        longint v;
        o = '0;
        o.res_row = r.out_row;
        o.res_col = r.out_col;
        o.res_chan = r.out_chan;
        row = r.out_row;
        col = r.out_col;
        chan = r.out_chan;
        if (chan < CH_OUT)
        begin
            acc = 0;
            for (int ky = 0; ky < KERNEL; ky++)
            begin
                for (int kx = 0; kx < KERNEL; kx++)
                begin
                    h = row * STRIDE + ky;
                    w = col * STRIDE + kx;
                    // taps outside the map contribute nothing
                    if (h < H_IN && w < W_IN)
                    begin
                        for (int c = 0; c < CH_IN; c++)
                        begin
                            a = feat_mem[feat_addr(h, w, c)];
                            b = wgt_mem[wgt_addr(ky, kx, c, chan)];
                            acc -= (a >= b) ? (a - b) : (b - a);
                        end
                    end
                end
            end
            // floor of the scaled sum, then shift, relu and clip
            v = ((longint'(scale_mem[chan]) * longint'(acc)) >>> FRAC)
                + longint'(shift_mem[chan]);
            if (v < 0)
                v = 0;
            if (v > VAL_MAX)
            begin
                v = VAL_MAX;
                o.saturated = 1'b1;
            end
            o.result_value = VAL_W'(v);
        end
        return o;
    endfunction

    // apply one accepted request to the shadow stores
    function automatic void take_request(req_t r);
        case (r.command)
            CMD_LOAD_FEAT:  if (r.addr < FEAT_DEPTH) feat_mem[r.addr] = r.data;
            CMD_LOAD_WGT:   if (r.addr < WGT_DEPTH) wgt_mem[r.addr] = r.data;
            CMD_LOAD_SCALE: if (r.addr < CH_OUT) scale_mem[r.addr] = r.data;
            CMD_LOAD_SHIFT: if (r.addr < CH_OUT) shift_mem[r.addr] = r.data;
            CMD_COMPUTE:    expected_results.push_back(conv_result(r));
            default: ;
        endcase
    endfunction

    // idle count for one request, with occasional stretches of none
    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 99) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic req_t noise_req();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(req_t)-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] span_value(int lo, int hi);
        return DATA_W'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    // spread zero means any 16-bit pattern
    function automatic logic [DATA_W-1:0] map_value(int spread);
        if (spread == 0)
            return DATA_W'($urandom);
        return span_value(-spread, spread);
    endfunction

    function automatic void push_load(cmd_t cmd, int addr, logic [DATA_W-1:0] value);
        req_t r;
        r = noise_req();
        r.command = cmd;
        r.addr = ADDR_W'(addr);
        r.data = value;
        pending_reqs.push_back(r);
    endfunction

    function automatic void push_compute(int row, int col, int chan);
        req_t r;
        r = noise_req();
        r.command = CMD_COMPUTE;
        r.out_row = ROW_W'(row);
        r.out_col = COL_W'(col);
        r.out_chan = CHAN_W'(chan);
        pending_reqs.push_back(r);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_gap <= 0;
        end
        else if (!(req_valid && req_stall))
        begin
            if (req_valid)
            begin
                take_request(req);
                n_accepted++;
            end
            if (req_gap != 0)
            begin
                req_valid <= 1'b0;
                req_gap <= req_gap - 1;
            end
            else if (pending_reqs.size() != 0)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                req_gap <= draw_wait(req_quiet);
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // response monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        int   nxt;
        res_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_wait <= 0;
        end
        else
        begin
            nxt = rsp_wait;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected response %p", $time, rsp);
                    n_errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    n_results++;
                    if (want.saturated)
                        n_saturated++;
                    if (rsp.result_value !== want.result_value
                        || rsp.res_row !== want.res_row
                        || rsp.res_col !== want.res_col
                        || rsp.res_chan !== want.res_chan
                        || rsp.saturated !== want.saturated)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, rsp);
                        n_errors++;
                    end
                end
                nxt = draw_wait(rsp_quiet);
            end
            else if (rsp_wait != 0 && (rsp_valid || $urandom_range(0, 1) == 1))
            begin
                nxt = rsp_wait - 1;
            end
            rsp_wait <= nxt;
            rsp_stall <= (nxt != 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d responses still pending", $time,
                     expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin : sequencer
        int base;
        int ignored;
        int kind;
        int row;
        int col;
        int chan;
        int spread;
        int n;
        int ky;
        int kx;
        int c;
        int h;
        int w;
        req_t r;

        // fill every store so no compute reads an unwritten entry
        for (int i = 0; i < FEAT_DEPTH; i++)
            push_load(CMD_LOAD_FEAT, i,
                      ($urandom_range(0, 15) == 0) ? map_value(0) : map_value(384));
        for (int i = 0; i < WGT_DEPTH; i++)
            push_load(CMD_LOAD_WGT, i,
                      ($urandom_range(0, 15) == 0) ? map_value(0) : map_value(384));
        for (int i = 0; i < CH_OUT; i++)
        begin
            push_load(CMD_LOAD_SCALE, i, span_value(-80, 16));
            push_load(CMD_LOAD_SHIFT, i, span_value(-2048, 8191));
        end

        // corners and edges of the map, partial windows
        push_compute(0, 0, 0);
        push_compute(H_IN - 1, W_IN - 1, CH_OUT - 1);
        push_compute(0, W_IN - 1, 1);
        push_compute(H_IN - 1, 0, 2);

        // extreme difference at one tap with a unit negative scale
        push_load(CMD_LOAD_FEAT, 0, 16'h8000);
        push_load(CMD_LOAD_WGT, wgt_addr(0, 0, 0, 5), 16'h7fff);
        push_load(CMD_LOAD_SCALE, 5, 16'hffff);
        push_load(CMD_LOAD_SHIFT, 5, 16'h0000);
        push_compute(0, 0, 5);

        // most negative scale saturates, most positive clips at zero
        push_load(CMD_LOAD_SCALE, 1, 16'h8000);
        push_compute(7, 7, 1);
        push_load(CMD_LOAD_SCALE, 2, 16'h7fff);
        push_compute(7, 8, 2);

        // shift alone at the top and bottom of the range
        push_load(CMD_LOAD_SCALE, 3, 16'h0000);
        push_load(CMD_LOAD_SHIFT, 3, 16'h7fff);
        push_compute(3, 3, 3);
        push_load(CMD_LOAD_SCALE, 4, 16'h0000);
        push_load(CMD_LOAD_SHIFT, 4, 16'h8000);
        push_compute(4, 4, 4);

        // tiny scale: rounding of a negative product toward minus infinity
        push_load(CMD_LOAD_SCALE, 6, 16'h0001);
        push_load(CMD_LOAD_SHIFT, 6, 16'h4000);
        push_compute(9, 9, 6);

        // reserved commands and loads past the end of the weight, scale and shift stores
        for (int k = int'(CMD_COMPUTE) + 1; k < (1 << CMD_W); k++)
        begin
            r = noise_req();
            r.command = CMD_W'(k);
            pending_reqs.push_back(r);
        end
        push_load(CMD_LOAD_WGT, (1 << ADDR_W) - 1, 16'h1234);
        push_load(CMD_LOAD_SCALE, CH_OUT, 16'h7fff);
        push_load(CMD_LOAD_SHIFT, (1 << ADDR_W) - 1, 16'h7fff);
        push_compute(0, 0, 5);
        push_load(CMD_LOAD_FEAT, FEAT_DEPTH - 1, 16'h7fff);
        push_compute(H_IN - 1, W_IN - 1, CH_OUT - 1);

        // random sequences, often window updates followed by a compute
        base = pending_reqs.size();
        ignored = 0;
        while (pending_reqs.size() - base - ignored < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            row = $urandom_range(0, (1 << ROW_W) - 1);
            col = $urandom_range(0, (1 << COL_W) - 1);
            chan = $urandom_range(0, (1 << CHAN_W) - 1);
            spread = ($urandom_range(0, 3) == 0) ? 0 : 384;
            if (kind < 4)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    ky = $urandom_range(0, KERNEL - 1);
                    kx = $urandom_range(0, KERNEL - 1);
                    c = $urandom_range(0, CH_IN - 1);
                    h = row * STRIDE + ky;
                    w = col * STRIDE + kx;
                    if ($urandom_range(0, 1) == 1)
                        push_load(CMD_LOAD_FEAT, (h < H_IN && w < W_IN) ? feat_addr(h, w, c)
                                  : $urandom_range(0, FEAT_DEPTH - 1), map_value(spread));
                    else
                        push_load(CMD_LOAD_WGT, wgt_addr(ky, kx, c, chan % CH_OUT),
                                  map_value(spread));
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    push_load(CMD_LOAD_SCALE, chan % CH_OUT, span_value(-80, 16));
                    push_load(CMD_LOAD_SHIFT, chan % CH_OUT, span_value(-2048, 8191));
                end
                push_compute(row, col, chan);
            end
            else if (kind < 6)
            begin
                push_load(CMD_LOAD_SCALE, chan % CH_OUT,
                          ($urandom_range(0, 3) == 0) ? map_value(0) : span_value(-80, 16));
                push_load(CMD_LOAD_SHIFT, chan % CH_OUT, map_value(spread));
                repeat ($urandom_range(2, 4))
                    push_compute($urandom_range(0, (1 << ROW_W) - 1),
                                 $urandom_range(0, (1 << COL_W) - 1), chan);
            end
            else if (kind < 8)
            begin
                push_compute(row, col, chan);
            end
            else if (kind == 8)
            begin
                // raw noise, any command
                n = $urandom_range(1, 3);
                repeat (n)
                    pending_reqs.push_back(noise_req());
                ignored += n;
            end
            else
            begin
                // writes past the end must leave the stores alone
                push_load(CMD_LOAD_WGT, $urandom_range(WGT_DEPTH, (1 << ADDR_W) - 1),
                          map_value(0));
                push_load(CMD_LOAD_SCALE, $urandom_range(CH_OUT, (1 << ADDR_W) - 1),
                          map_value(0));
                push_load(CMD_LOAD_SHIFT, $urandom_range(CH_OUT, (1 << ADDR_W) - 1),
                          map_value(0));
                ignored += 3;
                push_compute(row, col, chan);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: map, weight, scale and shift loads, reserved",
                 n_accepted);
        $display("commands, out-of-range writes; %0d compute results checked, %0d saturated",
                 n_results, n_saturated);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
